/* sv/sacl_pkg.sv */
// Shared constants, types and helpers of the set-associative LRU tag store.
`timescale 1ns / 1ps

package sacl_pkg;

   localparam int WAYS        = 4;
   localparam int OFFSET_BITS = 2;
   localparam int INDEX_BITS  = 14;
   localparam int ADDR_BITS   = 32;
   localparam int COUNT_BITS  = 32;
   localparam int WAY_OUT_BITS = 2;

   localparam int SETS      = 1 << INDEX_BITS;
   localparam int TAG_SHIFT = OFFSET_BITS + INDEX_BITS;
   localparam int TAG_BITS  = ADDR_BITS - TAG_SHIFT;
   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;

   // hit, way, hit count, access count, padded to whole bytes
   localparam int RSP_FIELD_BITS = 1 + WAY_OUT_BITS + 2 * COUNT_BITS;
   localparam int RSP_BITS       = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [TAG_BITS-1:0]   tag_type;
   typedef logic [WAY_BITS-1:0]   way_type;
   typedef tag_type [WAYS-1:0]    tag_row_type;
   // slot 0 holds the oldest way, slot WAYS-1 the newest
   typedef way_type [WAYS-1:0]    order_type;

   typedef struct packed {
      order_type        order;
      logic [WAYS-1:0]  valid;
   } meta_type;

   // controller to datapath
   typedef struct packed {
      logic clear_we;   // write the reset value of one set and advance
      logic lookup_rd;  // latch the address and read its set
      logic commit;     // write the set back and load the result word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;  // clearing pointer is at the last set
      logic out_free;    // result register can take a word this cycle
   } sts_type;

   function automatic order_type reset_order();
      order_type ord;
      for (int i = 0; i < WAYS; i++) begin
         ord[i] = WAY_BITS'(i);
      end
      return ord;
   endfunction

   function automatic logic [WAY_OUT_BITS-1:0] way_field(input way_type way);
      return WAY_OUT_BITS'(way);
   endfunction

endpackage

/* sv/sacl_ctrl.sv */
// Controller: clearing pass after reset, then accept, look up and commit.
`timescale 1ns / 1ps

module sacl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sacl_pkg::sts_type sts,
   output sacl_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready    = (state_ff == ST_IDLE);
   assign cmd.clear_we  = (state_ff == ST_CLEAR);
   assign cmd.lookup_rd = req_tready && req_tvalid;
   assign cmd.commit    = (state_ff == ST_LOOKUP) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/sacl_datapath.sv */
// Datapath: set memories, tag compare, LRU update, counters and result register.
`timescale 1ns / 1ps

module sacl_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  sacl_pkg::cmd_type                 cmd,
   output sacl_pkg::sts_type                 sts,
   input  logic [sacl_pkg::ADDR_BITS-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sacl_pkg::RSP_BITS-1:0]     rsp_tdata
);

   sacl_pkg::meta_type    meta_mem [sacl_pkg::SETS];
   sacl_pkg::tag_row_type tag_mem  [sacl_pkg::SETS];

   sacl_pkg::index_type   clr_addr_ff;
   sacl_pkg::index_type   index_ff;
   sacl_pkg::tag_type     tag_ff;
   sacl_pkg::meta_type    meta_rd_ff;
   sacl_pkg::tag_row_type tags_rd_ff;

   logic                                 out_valid_ff;
   logic                                 out_hit_ff;
   sacl_pkg::way_type                    out_way_ff;
   logic [sacl_pkg::COUNT_BITS-1:0]      hit_total_ff;
   logic [sacl_pkg::COUNT_BITS-1:0]      access_total_ff;

   logic                  hit;
   sacl_pkg::way_type     hit_way;
   sacl_pkg::way_type     way;
   sacl_pkg::way_type     pos;
   sacl_pkg::meta_type    meta_wr;
   sacl_pkg::tag_row_type tags_wr;
   sacl_pkg::meta_type    meta_clr;
   sacl_pkg::index_type   wr_addr;

   assign sts.clear_last = (clr_addr_ff == sacl_pkg::index_type'(sacl_pkg::SETS - 1));
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   // tag compare, lowest matching way wins
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
         if (meta_rd_ff.valid[w] && (tags_rd_ff[w] == tag_ff)) begin
            hit     = 1'b1;
            hit_way = sacl_pkg::WAY_BITS'(w);
         end
      end
   end

   assign way = hit ? hit_way : meta_rd_ff.order[0];

   // move the used way to the newest end of the order
   always_comb begin
      pos = '0;
      for (int i = 0; i < sacl_pkg::WAYS; i++) begin
         if (meta_rd_ff.order[i] == way) begin
            pos = sacl_pkg::WAY_BITS'(i);
         end
      end
      meta_wr.valid = meta_rd_ff.valid;
      if (!hit) begin
         meta_wr.valid[way] = 1'b1;
      end
      for (int i = 0; i < sacl_pkg::WAYS - 1; i++) begin
         if (i >= int'(pos)) begin
            meta_wr.order[i] = meta_rd_ff.order[i + 1];
         end else begin
            meta_wr.order[i] = meta_rd_ff.order[i];
         end
      end
      meta_wr.order[sacl_pkg::WAYS - 1] = way;
      tags_wr = tags_rd_ff;
      tags_wr[way] = tag_ff;
   end

   assign meta_clr.order = sacl_pkg::reset_order();
   assign meta_clr.valid = '0;
   assign wr_addr = cmd.clear_we ? clr_addr_ff : index_ff;

   // set metadata memory
   always_ff @(posedge clock) begin
      if (cmd.clear_we || cmd.commit) begin
         meta_mem[wr_addr] <= cmd.clear_we ? meta_clr : meta_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup_rd) begin
         meta_rd_ff <= meta_mem[req_tdata[sacl_pkg::OFFSET_BITS +: sacl_pkg::INDEX_BITS]];
      end
   end

   // tag memory, never cleared
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tag_mem[index_ff] <= tags_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup_rd) begin
         tags_rd_ff <= tag_mem[req_tdata[sacl_pkg::OFFSET_BITS +: sacl_pkg::INDEX_BITS]];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.lookup_rd) begin
         index_ff <= req_tdata[sacl_pkg::OFFSET_BITS +: sacl_pkg::INDEX_BITS];
         tag_ff   <= req_tdata[sacl_pkg::TAG_SHIFT +: sacl_pkg::TAG_BITS];
      end
      if (cmd.commit) begin
         out_hit_ff <= hit;
         out_way_ff <= way;
      end
   end

   // control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff     <= '0;
         out_valid_ff    <= 1'b0;
         hit_total_ff    <= '0;
         access_total_ff <= '0;
      end else begin
         if (cmd.clear_we) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.commit) begin
            out_valid_ff    <= 1'b1;
            access_total_ff <= access_total_ff + 1'b1;
            if (hit) begin
               hit_total_ff <= hit_total_ff + 1'b1;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = sacl_pkg::RSP_BITS'({access_total_ff, hit_total_ff,
                                            sacl_pkg::way_field(out_way_ff), out_hit_ff});

endmodule

/* sv/set_assoc_cache_lru_lookup.sv */
// Top level: four-way set-associative tag store with exact LRU replacement.
// The set and address are registered when an address word is taken; the compare,
//   write-back and result word load follow in the LOOKUP state.
// A new address is taken only after the set is written back, back in the IDLE state;
//   a stalled result word holds the write-back and with it the next take.
// Reset: synchronous; then a clearing pass (one set a cycle), req_tready low.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sacl_pkg::ADDR_BITS-1:0]    req_tdata,  // [31:0] address
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] hit, [2:1] way_used, [34:3] hit_total, [66:35] access_total, rest zero
   output logic [sacl_pkg::RSP_BITS-1:0]     rsp_tdata
);

   sacl_pkg::cmd_type cmd;
   sacl_pkg::sts_type sts;

   // sequence the clearing pass and each lookup
   sacl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // hold the set memories, counters and the result register
   sacl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // one word at a time: after a take, hold off for the lookup cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("address taken during lookup");

   // no word is taken while the clearing pass runs
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_we |-> !req_tready)
      else $error("address taken during clearing pass");

   // a commit always presents a result word
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit without result word");

   // the access count moves only on a commit
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(rsp_tdata[66:35]))
      else $error("access count moved without commit");

   // no clearing write follows a taken word
   a_commit_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !cmd.clear_we)
      else $error("clearing after a taken word");
`endif

endmodule

/* tb/sv/set_assoc_cache_lru_lookup_checker.sv */
// Scoreboard for the LRU tag store: predicts each lookup and checks every result word.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_checker
   import sacl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [ADDR_BITS-1:0]  req_tdata,   // [31:0] address
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_BITS-1:0]   rsp_tdata,   // [0] hit, [2:1] way, [34:3] hits, [66:35] accesses
   output int                    fail_count,
   output int                    pending,
   output int                    words_checked,
   output int                    hits_seen
);

   // field order gives hit the lowest bit
   typedef struct packed {
      logic [COUNT_BITS-1:0]   access_total;
      logic [COUNT_BITS-1:0]   hit_total;
      logic [WAY_OUT_BITS-1:0] way_used;
      logic                    hit;
   } lookup_word_type;

   logic [WAYS-1:0]       valid_mem [SETS];
   tag_row_type           tag_mem   [SETS];
   order_type             order_mem [SETS];
   logic [COUNT_BITS-1:0] hit_counter;
   logic [COUNT_BITS-1:0] access_counter;
   lookup_word_type       expected_words [$];
   int                    mismatches = 0;
   int                    compared = 0;
   int                    hits = 0;

   assign fail_count    = mismatches;
   assign words_checked = compared;
   assign hits_seen     = hits;

   task automatic report_mismatch(input string what, input logic [COUNT_BITS-1:0] got,
                                  input logic [COUNT_BITS-1:0] want);
      if (mismatches < 40) begin
         $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   // Look the address up in the shadow tag store and update it as the cache would.
   function automatic lookup_word_type predict_lookup(input logic [ADDR_BITS-1:0] addr);
      index_type       set;
      tag_type         tag;
      way_type         way;
      logic            hit;
      order_type       ord;
      int              pos;
      lookup_word_type word;
      set = addr[TAG_SHIFT-1:OFFSET_BITS];
      tag = addr[ADDR_BITS-1:TAG_SHIFT];
      hit = 1'b0;
      way = '0;
      pos = 0;
      // scan downwards so the lowest matching way wins
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (valid_mem[set][w] && tag_mem[set][w] == tag) begin
            hit = 1'b1;
            way = way_type'(w);
         end
      end
      if (!hit) begin
         way = order_mem[set][0];
         tag_mem[set][way]   = tag;
         valid_mem[set][way] = 1'b1;
      end
      ord = order_mem[set];
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (ord[i] == way) pos = i;
      end
      for (int i = pos; i < WAYS - 1; i++) begin
         ord[i] = ord[i+1];
      end
      ord[WAYS-1]    = way;
      order_mem[set] = ord;
      access_counter = access_counter + 1'b1;
      if (hit) hit_counter = hit_counter + 1'b1;
      word.hit          = hit;
      word.way_used     = WAY_OUT_BITS'(way);
      word.hit_total    = hit_counter;
      word.access_total = access_counter;
      return word;
   endfunction

   always @(posedge clock) begin : watch
      lookup_word_type got;
      lookup_word_type want;
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            valid_mem[s] = '0;
            for (int w = 0; w < WAYS; w++) begin
               order_mem[s][w] = way_type'(w);
            end
         end
         hit_counter    = '0;
         access_counter = '0;
         expected_words.delete();
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_FIELD_BITS-1:0];
            if (rsp_tdata[RSP_BITS-1:RSP_FIELD_BITS] != '0) begin
               report_mismatch("padding bits",
                               COUNT_BITS'(rsp_tdata[RSP_BITS-1:RSP_FIELD_BITS]), '0);
            end
            if (expected_words.size() == 0) begin
               report_mismatch("result word with no lookup waiting", got.access_total, '0);
            end else begin
               want = expected_words.pop_front();
               if (got.hit != want.hit) begin
                  report_mismatch("hit", COUNT_BITS'(got.hit), COUNT_BITS'(want.hit));
               end
               if (got.way_used != want.way_used) begin
                  report_mismatch("way_used", COUNT_BITS'(got.way_used),
                                  COUNT_BITS'(want.way_used));
               end
               if (got.hit_total != want.hit_total) begin
                  report_mismatch("hit_total", got.hit_total, want.hit_total);
               end
               if (got.access_total != want.access_total) begin
                  report_mismatch("access_total", got.access_total, want.access_total);
               end
               compared++;
               if (want.hit) hits++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_words.push_back(predict_lookup(req_tdata));
         end
         pending <= expected_words.size();
      end
   end

endmodule

/* tb/sv/set_assoc_cache_lru_lookup_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the LRU tag store: clock, reset, address stimulus and verdict.

module set_assoc_cache_lru_lookup_tb;
   import sacl_pkg::*;

   localparam int ITEM_COUNT  = 750;
   // clearing pass plus 750 lookups at worst-case gaps and stalls,
   // taken several times over
   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [ADDR_BITS-1:0] req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_BITS-1:0]  rsp_tdata;

   int   fail_count;
   int   pending;
   int   words_checked;
   int   hits_seen;
   int   cycle_count = 0;
   int   addresses_sent = 0;
   int   directed_sent = 0;
   // set during a stretch with no gaps on either side
   logic quiet = 1'b0;

   set_assoc_cache_lru_lookup i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   set_assoc_cache_lru_lookup_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .words_checked (words_checked),
      .hits_seen     (hits_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abandon the run if it hangs, e.g. a lost result word or a stuck ready.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still waiting", cycle_count, pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Mostly back to back, now and then a few idle cycles, rarely a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ADDR_BITS-1:0] make_address(input tag_type tag,
                                                         input index_type set,
                                                         input logic [OFFSET_BITS-1:0] offset);
      return {tag, set, offset};
   endfunction

   // Offer one address word and hold it until the block takes it.
   task automatic send_address(input logic [ADDR_BITS-1:0] addr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      addresses_sent++;
   endtask

   // Result side: alternate ready runs and stalls, always ready while quiet.
   initial begin : result_sink
      int   hold;
      logic level;
      hold  = 0;
      level = 1'b1;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (quiet) begin
            level = 1'b1;
            hold  = 0;
         end else if (hold == 0) begin
            if (level) begin
               hold = pick_gap();
               if (hold > 0) level = 1'b0;
               else hold = $urandom_range(1, 8);
            end else begin
               level = 1'b1;
               hold  = $urandom_range(1, 8);
            end
         end
         if (hold > 0) hold--;
         rsp_tready <= level;
      end
   end

   initial begin : stimulus
      logic [ADDR_BITS-1:0] addr;
      index_type            hot_sets [4];
      tag_type              hot_tags [6];
      int                   r;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Extremes of the address, and a hit that differs only in offset.
      send_address(32'h0000_0000);
      send_address(32'h0000_0003);
      send_address(32'hFFFF_FFFF);
      send_address(32'hFFFF_FFFC);
      send_address(32'hAAAA_AAAA);
      send_address(32'h5555_5555);
      // Same tag in a neighbouring set must miss.
      send_address(make_address(tag_type'(0), index_type'(1), '0));
      // Fill set 2: untouched ways go lowest index first.
      for (int t = 1; t <= 4; t++) begin
         send_address(make_address(tag_type'(t), index_type'(2), OFFSET_BITS'(t)));
      end
      // Touch way 0, so way 1 becomes the oldest and is evicted next.
      send_address(make_address(tag_type'(1), index_type'(2), '0));
      send_address(make_address(tag_type'(5), index_type'(2), '0));
      // The evicted tag comes back and takes way 2; then refill way 3.
      send_address(make_address(tag_type'(2), index_type'(2), '0));
      send_address(make_address(tag_type'(1), index_type'(2), '1));
      send_address(make_address(tag_type'(3), index_type'(2), '0));
      send_address(make_address(tag_type'(5), index_type'(2), '0));
      // Top set with the five highest tags, one more than ways, then the evicted top tag again.
      for (int t = 0; t < 5; t++) begin
         send_address(make_address(tag_type'(16'hFFFF - t), '1, '0));
      end
      send_address(make_address(tag_type'(16'hFFFF), '1, '1));
      directed_sent = addresses_sent;

      // Random part: mostly a few hot sets and a small tag pool, so that hits,
      // refills and evictions keep coming; the rest is any address at all.
      for (int i = 0; i < ITEM_COUNT; i++) begin
         if (i % 50 == 0) begin
            foreach (hot_sets[k]) hot_sets[k] = index_type'($urandom);
            foreach (hot_tags[k]) hot_tags[k] = tag_type'($urandom);
            if (i % 150 == 0) begin
               hot_sets[0] = '0;
               hot_sets[1] = '1;
            end
         end
         quiet = (i >= 300 && i < 400);
         r = $urandom_range(0, 99);
         if (r < 75) begin
            addr = make_address(hot_tags[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 3)],
                                OFFSET_BITS'($urandom));
         end else begin
            addr = $urandom;
         end
         send_address(addr);
      end
      req_tvalid <= 1'b0;
      quiet = 1'b0;

      // Drain: let the last push show up in the pending count, then wait it out.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d addresses (%0d directed), %0d result words compared, %0d hits.",
               addresses_sent, directed_sent, words_checked, hits_seen);
      $display("Covered LRU fill and eviction, offset-only hits and random ready/valid gaps.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/sacl_pkg.sv
sv/sacl_ctrl.sv
sv/sacl_datapath.sv
sv/set_assoc_cache_lru_lookup.sv
tb/sv/set_assoc_cache_lru_lookup_checker.sv
tb/sv/set_assoc_cache_lru_lookup_tb.sv
